FILE: rtl/ptkp_pkg.sv
// ----------------------------------------------------------------------------
// ptkp_pkg
// Types, constants and helpers shared by the projection top-k pool unit.
// ----------------------------------------------------------------------------
package ptkp_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DirW   = 18;
  localparam int unsigned CapW   = 5;
  localparam int unsigned RankW  = 4;
  localparam int unsigned ProdW  = DirW + CoordW + 1;
  localparam int unsigned ScoreW = 36;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [1:0] REG_DIR_X = 2'd0;
  localparam logic [1:0] REG_DIR_Y = 2'd1;
  localparam logic [1:0] REG_DIR_Z = 2'd2;
  localparam logic [1:0] REG_CAP   = 2'd3;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic signed [DirW-1:0] x;
    logic signed [DirW-1:0] y;
    logic signed [DirW-1:0] z;
  } dir_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [IdW-1:0]           id;
  } entry_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic   valid;
    logic   beats;
    entry_t entry;
  } cell_bus_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   insert;
    logic   shift;
    entry_t cand;
  } cell_ctrl_t;

  function automatic logic ranks_above(entry_t a, entry_t b);
    return (a.score > b.score) || ((a.score == b.score) && (a.id < b.id));
  endfunction

endpackage

FILE: rtl/ptkp_point_if.sv
// ----------------------------------------------------------------------------
// ptkp_point_if
// Valid/ready channel carrying one input point per transaction.
// ----------------------------------------------------------------------------
interface ptkp_point_if import ptkp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IdW-1:0]    point_id;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;
  logic [CoordW-1:0] coord_z;
  logic              final_point;

  modport source (output valid, point_id, coord_x, coord_y, coord_z, final_point,
                  input ready);
  modport sink (input valid, point_id, coord_x, coord_y, coord_z, final_point,
                output ready);
endinterface

FILE: rtl/ptkp_result_if.sv
// ----------------------------------------------------------------------------
// ptkp_result_if
// Valid/ready channel carrying one ranked pool entry per transaction.
// ----------------------------------------------------------------------------
interface ptkp_result_if import ptkp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [RankW-1:0]         rank;
  logic [IdW-1:0]           best_id;
  logic signed [ScoreW-1:0] best_score;
  logic                     run_end;

  modport source (output valid, rank, best_id, best_score, run_end, input ready);
  modport sink (input valid, rank, best_id, best_score, run_end, output ready);
endinterface

FILE: rtl/projection_top_k_pool_unit.sv
// ----------------------------------------------------------------------------
// projection_top_k_pool_unit
// Keeps the best-scoring points of a stream in a sorted chain of pool cells.
// ----------------------------------------------------------------------------
// Points arrive on point_i (valid/ready), results leave on result_o.
// Each point is scored against the direction set over APB and inserted
// into a chain of POOL_DEPTH cells, one point per cycle while point_i.ready
// is high; the score is registered as products, then as a sum, and the
// insertion is registered in the cells. A point with final_point set
// closes the set: point_i.ready drops while it moves through the score
// pipeline, then the pool is read out from the head cell one entry per
// cycle while result_o.ready is high, rank 0 first, run_end on the last one.
// The next point waits until every entry is taken; during the readout a
// low result_o.ready holds the chain. Reset empties the pool, clears the
// direction to zero and sets the capacity to one. APB registers sit at
// 0x0 dir_x, 0x4 dir_y, 0x8 dir_z, 0xC pool_capacity; writes take effect
// at once, reads return the stored value, pready is always high.
// ----------------------------------------------------------------------------
module projection_top_k_pool_unit import ptkp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptkp_point_if.sink        point_i,
  ptkp_result_if.source     result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  dir_t            dir_q;
  logic [CapW-1:0] cap_q;
  logic [CapW-1:0] cap_lim;
  logic            cfg_wr;

  state_e          state_q, state_d;
  logic [RankW-1:0] rank_q, rank_d;

  logic            final_pend;
  logic            sc_valid, sc_final;
  entry_t          sc_entry;
  cell_ctrl_t      ctrl;
  logic            out_hs;
  logic            run_end;

  cell_bus_t       cell_bus [POOL_DEPTH];
  cell_bus_t       prev_bus [POOL_DEPTH];
  cell_bus_t       next_bus [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] cell_en;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0;
      cap_q <= CapW'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DIR_X: dir_q.x <= pwdata[DirW-1:0];
        REG_DIR_Y: dir_q.y <= pwdata[DirW-1:0];
        REG_DIR_Z: dir_q.z <= pwdata[DirW-1:0];
        REG_CAP:   cap_q   <= pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIR_X: prdata = {{(DataW-DirW){1'b0}}, dir_q.x};
      REG_DIR_Y: prdata = {{(DataW-DirW){1'b0}}, dir_q.y};
      REG_DIR_Z: prdata = {{(DataW-DirW){1'b0}}, dir_q.z};
      REG_CAP:   prdata = {{(DataW-CapW){1'b0}}, cap_q};
      default:   prdata = '0;
    endcase
  end

  assign cap_lim = (cap_q == '0) ? CapW'(1) : cap_q;

  // scoring
  ptkp_score u_score (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_q),
    .valid_i      (point_i.valid & point_i.ready),
    .id_i         (point_i.point_id),
    .x_i          (point_i.coord_x),
    .y_i          (point_i.coord_y),
    .z_i          (point_i.coord_z),
    .final_i      (point_i.final_point),
    .final_pend_o (final_pend),
    .valid_o      (sc_valid),
    .final_o      (sc_final),
    .entry_o      (sc_entry)
  );

  // control
  assign out_hs  = result_o.valid & result_o.ready;
  assign run_end = !cell_bus[1].valid;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN:   if (sc_valid && sc_final) state_d = ST_DRAIN;
      ST_DRAIN: if (out_hs && run_end) state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  always_comb begin
    rank_d = rank_q;
    if (out_hs) begin
      rank_d = run_end ? '0 : rank_q + RankW'(1);
    end
  end

  always_comb begin
    point_i.ready  = 1'b0;
    result_o.valid = 1'b0;
    ctrl.insert    = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.cand      = sc_entry;
    case (state_q)
      ST_RUN: begin
        point_i.ready = !final_pend;
        ctrl.insert   = sc_valid;
      end
      ST_DRAIN: begin
        result_o.valid = cell_bus[0].valid;
        ctrl.shift     = out_hs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

  assign result_o.rank       = rank_q;
  assign result_o.best_id    = cell_bus[0].entry.id;
  assign result_o.best_score = cell_bus[0].entry.score;
  assign result_o.run_end    = run_end;

  // pool chain
  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    if (k < 32) begin : g_en
      assign cell_en[k] = cap_lim > CapW'(k);
    end else begin : g_off
      assign cell_en[k] = 1'b0;
    end

    if (k == 0) begin : g_head
      assign prev_bus[k] = '0;
    end else begin : g_prev
      assign prev_bus[k] = cell_bus[k-1];
    end

    if (k == POOL_DEPTH - 1) begin : g_tail
      assign next_bus[k] = '0;
    end else begin : g_next
      assign next_bus[k] = cell_bus[k+1];
    end

    ptkp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .en_i   (cell_en[k]),
      .prev_i (prev_bus[k]),
      .next_i (next_bus[k]),
      .cell_o (cell_bus[k])
    );
  end

endmodule

FILE: rtl/ptkp_score.sv
// ----------------------------------------------------------------------------
// ptkp_score
// Two-stage dot product: three registered products, then a registered sum.
// ----------------------------------------------------------------------------
module ptkp_score import ptkp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dir_t              dir_i,
  input  logic              valid_i,
  input  logic [IdW-1:0]    id_i,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [CoordW-1:0] z_i,
  input  logic              final_i,
  output logic              final_pend_o,
  output logic              valid_o,
  output logic              final_o,
  output entry_t            entry_o
);

  logic                    s1_valid_q, s1_final_q;
  logic                    s2_valid_q, s2_final_q;
  logic [IdW-1:0]          s1_id_q;
  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  entry_t                  s2_entry_q;
  logic signed [ScoreW-1:0] sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_final_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_final_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s1_final_q <= valid_i & final_i;
      s2_valid_q <= s1_valid_q;
      s2_final_q <= s1_final_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_id_q <= id_i;
    px_q    <= dir_i.x * $signed({1'b0, x_i});
    py_q    <= dir_i.y * $signed({1'b0, y_i});
    pz_q    <= dir_i.z * $signed({1'b0, z_i});
    s2_entry_q.score <= sum_d;
    s2_entry_q.id    <= s1_id_q;
  end

  assign sum_d = ScoreW'(px_q) + ScoreW'(py_q) + ScoreW'(pz_q);

  assign final_pend_o = s1_final_q | s2_final_q;
  assign valid_o      = s2_valid_q;
  assign final_o      = s2_final_q;
  assign entry_o      = s2_entry_q;

endmodule

FILE: rtl/ptkp_cell.sv
// ----------------------------------------------------------------------------
// ptkp_cell
// One pool slot: compares the candidate, takes it or the better neighbor's
// entry, empties past the capacity, or takes the next entry on readout.
// ----------------------------------------------------------------------------
module ptkp_cell import ptkp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       en_i,
  input  cell_bus_t  prev_i,
  input  cell_bus_t  next_i,
  output cell_bus_t  cell_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   beats;

  assign beats = !valid_q || ranks_above(ctrl_i.cand, entry_q);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      entry_d = next_i.entry;
    end else if (ctrl_i.insert) begin
      if (!en_i) begin
        valid_d = 1'b0;
      end else if (beats && prev_i.beats) begin
        valid_d = prev_i.valid;
        entry_d = prev_i.entry;
      end else if (beats) begin
        valid_d = 1'b1;
        entry_d = ctrl_i.cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.beats = beats;
  assign cell_o.entry = entry_q;

endmodule
